// ===== rtl/core/hsc_pkg.sv =====
package hsc_pkg;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned TEMP_W     = 9;
    localparam int unsigned SP_W       = 7;
    localparam int unsigned BAND_W     = 5;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned IDLE_W     = 10;
    localparam int unsigned BLINK_W    = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned RES_W      = 22;
    localparam int unsigned RES_BYTES  = 3;

    localparam int unsigned TEMP_SCALE = 500;

    localparam logic [BAND_W-1:0]  BAND_RST    = BAND_W'(5);
    localparam logic [SP_W-1:0]    SP_MIN_RST  = SP_W'(35);
    localparam logic [SP_W-1:0]    SP_MAX_RST  = SP_W'(75);
    localparam logic [STEP_W-1:0]  SP_STEP_RST = STEP_W'(5);
    localparam logic [IDLE_W-1:0]  TIMEOUT_RST = IDLE_W'(315);
    localparam logic [BLINK_W-1:0] BLINK_RST   = BLINK_W'(61);
    localparam logic [SP_W-1:0]    SP_RST      = SP_W'(60);
    localparam logic [IDLE_W-1:0]  IDLE_MAX    = '1;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 3'd0,
        OP_POWER  = 3'd1,
        OP_UP     = 3'd2,
        OP_DOWN   = 3'd3,
        OP_TICK   = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAND     = 3'd0,
        CFG_SP_MIN   = 3'd1,
        CFG_SP_MAX   = 3'd2,
        CFG_SP_STEP  = 3'd3,
        CFG_TIMEOUT  = 3'd4,
        CFG_BLINK    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [SP_W-1:0]    sp_min;
        logic [SP_W-1:0]    sp_max;
        logic [STEP_W-1:0]  sp_step;
        logic [IDLE_W-1:0]  timeout_ticks;
        logic [BLINK_W-1:0] blink_ticks;
    } t_cfg;

    // packed from the highest field down, so heater_on lands in bit 0
    typedef struct packed {
        logic              powered;
        logic              in_set_mode;
        logic [SP_W-1:0]   setpoint_now;
        logic              display_on;
        logic [TEMP_W-1:0] display_value;
        logic              lamp_on;
        logic              cooler_on;
        logic              heater_on;
    } t_res;

endpackage

// ===== rtl/core/hsc_cfg.sv =====
module hsc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output hsc_pkg::t_cfg                    o_cfg
);

    hsc_pkg::t_cfg r_cfg;
    hsc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (hsc_pkg::t_cfg_idx'(i_cfg_index))
                hsc_pkg::CFG_BAND:    n_cfg.band          = i_cfg_data[hsc_pkg::BAND_W-1:0];
                hsc_pkg::CFG_SP_MIN:  n_cfg.sp_min        = i_cfg_data[hsc_pkg::SP_W-1:0];
                hsc_pkg::CFG_SP_MAX:  n_cfg.sp_max        = i_cfg_data[hsc_pkg::SP_W-1:0];
                hsc_pkg::CFG_SP_STEP: n_cfg.sp_step       = i_cfg_data[hsc_pkg::STEP_W-1:0];
                hsc_pkg::CFG_TIMEOUT: n_cfg.timeout_ticks = i_cfg_data[hsc_pkg::IDLE_W-1:0];
                hsc_pkg::CFG_BLINK:   n_cfg.blink_ticks   = i_cfg_data[hsc_pkg::BLINK_W-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band          <= hsc_pkg::BAND_RST;
            r_cfg.sp_min        <= hsc_pkg::SP_MIN_RST;
            r_cfg.sp_max        <= hsc_pkg::SP_MAX_RST;
            r_cfg.sp_step       <= hsc_pkg::SP_STEP_RST;
            r_cfg.timeout_ticks <= hsc_pkg::TIMEOUT_RST;
            r_cfg.blink_ticks   <= hsc_pkg::BLINK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/core/hsc_avg.sv =====
module hsc_avg #(
    parameter int unsigned AVG_DEPTH = 10,
    parameter int unsigned ADC_BITS  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [ADC_BITS-1:0]           i_raw,
    output logic [hsc_pkg::TEMP_W-1:0]    o_avg
);

    localparam int unsigned IDX_W  = $clog2(AVG_DEPTH);
    localparam int unsigned SUM_W  = hsc_pkg::TEMP_W + IDX_W;
    localparam int unsigned SHIFT  = SUM_W + IDX_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam int unsigned RECIP_W = $clog2(RECIP + 1);
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;
    localparam int unsigned SCL_W   = ADC_BITS + hsc_pkg::TEMP_W;

    localparam logic [RECIP_W-1:0]         RECIP_V = RECIP_W'(RECIP);
    localparam logic [hsc_pkg::TEMP_W-1:0] SCALE_V = hsc_pkg::TEMP_W'(hsc_pkg::TEMP_SCALE);
    localparam logic [IDX_W-1:0]           IDX_LAST = IDX_W'(AVG_DEPTH - 1);

    logic [hsc_pkg::TEMP_W-1:0] r_ring [AVG_DEPTH];
    logic [IDX_W-1:0]           r_idx;
    logic [SUM_W-1:0]           r_sum;
    logic [hsc_pkg::TEMP_W-1:0] r_avg;

    logic [SCL_W-1:0]           scaled;
    logic [hsc_pkg::TEMP_W-1:0] temp;
    logic [SUM_W-1:0]           n_sum;
    logic [PROD_W-1:0]          prod;
    logic [hsc_pkg::TEMP_W-1:0] n_avg;
    logic [IDX_W-1:0]           n_idx;

    always_comb begin
        scaled = SCL_W'(i_raw) * SCL_W'(SCALE_V);
        temp   = scaled[ADC_BITS +: hsc_pkg::TEMP_W];
        n_sum  = r_sum - SUM_W'(r_ring[r_idx]) + SUM_W'(temp);
        prod   = PROD_W'(n_sum) * PROD_W'(RECIP_V);
        n_avg  = prod[SHIFT +: hsc_pkg::TEMP_W];
        n_idx  = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
    end

    assign o_avg = i_we ? n_avg : r_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AVG_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_idx <= '0;
            r_sum <= '0;
            r_avg <= '0;
        end else if (i_we) begin
            r_ring[r_idx] <= temp;
            r_idx         <= n_idx;
            r_sum         <= n_sum;
            r_avg         <= n_avg;
        end
    end

endmodule

// ===== rtl/core/hysteresis_thermostat_controller.sv =====
// Hysteresis thermostat controller.
// Event requests arrive on the s_axis channel: tuser carries the event kind
// (sample, power button, up, down, tick) and tdata the raw converter reading.
// Each accepted request yields exactly one result on m_axis: drive bits,
// display value and blanking, current setpoint, set mode and power flags.
// Results are registered: an accepted request shows its result in the next
// cycle. Throughput: one request per cycle unless m_axis stalls; the critical
// path is the ring-sum update then the reciprocal multiply that averages it.
// Configuration writes use the cfg channel, always ready, one register each.
// Reset clears power, set mode, the averaging ring, timers and drives, sets
// the setpoint to 60 and restores the register defaults.
// When the receiver stalls, the result holds in the output register and a
// new request is taken only in a cycle where that register empties.
module hysteresis_thermostat_controller #(
    parameter int unsigned AVG_DEPTH = 10,
    parameter int unsigned ADC_BITS  = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((ADC_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,  // adc_sample
    input  logic [hsc_pkg::OP_W-1:0]             s_axis_tuser,  // op
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // heater_on, cooler_on, lamp_on, display_value, display_on,
    // setpoint_now, in_set_mode, powered
    output logic [hsc_pkg::RES_BYTES*8-1:0]      m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hsc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    hsc_pkg::t_cfg cfg;

    logic                          accept;
    logic                          sample_we;
    logic [hsc_pkg::TEMP_W-1:0]    avg;

    logic                          r_power,  n_power;
    logic                          r_set,    n_set;
    logic [hsc_pkg::SP_W-1:0]      r_sp,     n_sp;
    logic [hsc_pkg::IDLE_W-1:0]    r_idle,   n_idle;
    logic [hsc_pkg::BLINK_W-1:0]   r_blink,  n_blink;
    logic                          r_phase,  n_phase;
    logic [2:0]                    r_drive,  n_drive;
    logic                          r_out_valid;
    hsc_pkg::t_res                 r_res,    n_res;

    logic [hsc_pkg::SP_W:0]        sp_up;
    logic [hsc_pkg::SP_W:0]        sp_floor;
    logic [hsc_pkg::SP_W:0]        cool_at;
    logic [hsc_pkg::TEMP_W:0]      heat_at;
    logic [hsc_pkg::IDLE_W-1:0]    idle_inc;
    logic [hsc_pkg::BLINK_W-1:0]   blink_inc;

    hsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hsc_avg #(
        .AVG_DEPTH (AVG_DEPTH),
        .ADC_BITS  (ADC_BITS)
    ) u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (sample_we),
        .i_raw   (s_axis_tdata[ADC_BITS-1:0]),
        .o_avg   (avg)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sample_we     = accept && r_power && !r_set
                           && (hsc_pkg::t_op'(s_axis_tuser) == hsc_pkg::OP_SAMPLE);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = (hsc_pkg::RES_BYTES*8)'(r_res);

    always_comb begin
        n_power = r_power;
        n_set   = r_set;
        n_sp    = r_sp;
        n_idle  = r_idle;
        n_blink = r_blink;
        n_phase = r_phase;
        n_drive = r_drive;

        sp_up     = {1'b0, r_sp} + (hsc_pkg::SP_W + 1)'(cfg.sp_step);
        sp_floor  = {1'b0, cfg.sp_min} + (hsc_pkg::SP_W + 1)'(cfg.sp_step);
        cool_at   = {1'b0, r_sp} + (hsc_pkg::SP_W + 1)'(cfg.band);
        heat_at   = {1'b0, avg} + (hsc_pkg::TEMP_W + 1)'(cfg.band);
        idle_inc  = (r_idle != hsc_pkg::IDLE_MAX) ? r_idle + 1'b1 : r_idle;
        blink_inc = r_blink + 1'b1;

        case (hsc_pkg::t_op'(s_axis_tuser)) inside
            hsc_pkg::OP_SAMPLE: begin
                if (sample_we) begin
                    if (heat_at <= (hsc_pkg::TEMP_W + 1)'(r_sp)) begin
                        n_drive = 3'b001;
                    end else if ((hsc_pkg::SP_W + 2)'(avg) >= (hsc_pkg::SP_W + 2)'(cool_at)) begin
                        n_drive = 3'b110;
                    end
                end
            end
            hsc_pkg::OP_POWER: begin
                n_power = !r_power;
            end
            hsc_pkg::OP_UP, hsc_pkg::OP_DOWN: begin
                if (r_power) begin
                    n_idle  = '0;
                    n_phase = 1'b0;
                    if (!r_set) begin
                        n_set = 1'b1;
                    end else if (hsc_pkg::t_op'(s_axis_tuser) == hsc_pkg::OP_UP) begin
                        if (r_sp < cfg.sp_max) begin
                            n_sp = (sp_up > {1'b0, cfg.sp_max}) ? cfg.sp_max
                                                                : sp_up[hsc_pkg::SP_W-1:0];
                        end
                    end else begin
                        if (r_sp > cfg.sp_min) begin
                            n_sp = ({1'b0, r_sp} >= sp_floor) ? r_sp - (hsc_pkg::SP_W)'(cfg.sp_step)
                                                              : cfg.sp_min;
                        end
                    end
                end
            end
            hsc_pkg::OP_TICK: begin
                if (r_set) begin
                    if (idle_inc >= cfg.timeout_ticks) begin
                        n_set  = 1'b0;
                        n_idle = '0;
                    end else begin
                        n_idle = idle_inc;
                    end
                end else begin
                    n_idle = '0;
                end
                if (blink_inc >= cfg.blink_ticks) begin
                    n_phase = !r_phase;
                    n_blink = '0;
                end else begin
                    n_blink = blink_inc;
                end
            end
            default: begin
                n_power = r_power;
            end
        endcase

        if (!n_power || n_set) begin
            n_drive = 3'b000;
        end
    end

    always_comb begin
        n_res               = '0;
        n_res.setpoint_now  = n_sp;
        n_res.in_set_mode   = n_set;
        n_res.powered       = n_power;
        if (n_power) begin
            if (n_set) begin
                if (!n_phase) begin
                    n_res.display_on    = 1'b1;
                    n_res.display_value = hsc_pkg::TEMP_W'(n_sp);
                end
            end else begin
                n_res.heater_on     = n_drive[0];
                n_res.cooler_on     = n_drive[1];
                n_res.lamp_on       = n_drive[1] ? n_drive[2] : (n_drive[0] && !n_phase);
                n_res.display_on    = 1'b1;
                n_res.display_value = avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power     <= 1'b0;
            r_set       <= 1'b0;
            r_sp        <= hsc_pkg::SP_RST;
            r_idle      <= '0;
            r_blink     <= '0;
            r_phase     <= 1'b0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_power <= n_power;
                r_set   <= n_set;
                r_sp    <= n_sp;
                r_idle  <= n_idle;
                r_blink <= n_blink;
                r_phase <= n_phase;
                r_drive <= n_drive;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

endmodule
